// ----- rtl/qpd_pkg.sv -----
// Shared constants, types and helper functions for the quoted-printable decoder.
package qpd_pkg;

  // Characters the decoder looks for.
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_F    = 8'h46;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_F    = 8'h66;
  localparam logic [7:0] HEX_UPPER_OFS = CH_UPPER_A - 8'd10;
  localparam logic [7:0] HEX_LOWER_OFS = CH_LOWER_A - 8'd10;

  // One input beat yields at most this many result beats.
  localparam int MAX_RESULTS = 3;
  localparam int GRP_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Result queue sizing.
  localparam int QUEUE_DEPTH = MAX_RESULTS + 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_end;
    logic       message_end;
  } result_t;

  // All results caused by one input beat, in order from index 0.
  typedef struct packed {
    logic [GRP_CNT_W-1:0]           count;
    result_t [MAX_RESULTS-1:0]      item;
  } result_grp_t;

  // True when the character is a hex digit in either case.
  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_F));
  endfunction

  // Nibble value of a hex digit; only meaningful when is_hex holds.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c <= CH_UPPER_F) begin
      v = c - HEX_UPPER_OFS;
    end else begin
      v = c - HEX_LOWER_OFS;
    end
    return v[3:0];
  endfunction

  // Plain byte pass-through, with underscore turned into space in header mode.
  function automatic logic [7:0] map_plain(input logic [7:0] c, input logic hdr_mode);
    return ((c == CH_UNDERSCORE) && hdr_mode) ? CH_SPACE : c;
  endfunction

endpackage

// ----- rtl/qpd_in_if.sv -----
// Input channel carrying encoded bytes with an end-of-message flag.
interface qpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- rtl/qpd_out_if.sv -----
// Result channel carrying decoded bytes and end markers.
interface qpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output out_byte, output has_byte, output run_end,
                  output message_end, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input run_end,
                  input message_end, output ready);
endinterface

// ----- rtl/quoted_printable_decoder_top.sv -----
// Top level of the quoted-printable decoder.
//
//   Port     Dir  Beat contents
//   in_ch    in   in_byte[7:0], last_byte
//   out_ch   out  out_byte[7:0], has_byte, run_end, message_end
//   cfg_*    in   cfg_we, cfg_wdata = underscore_is_space (header mode)
//
// An input beat is decoded in the cycle it is accepted and its results sit in
// the result queue at the next edge; one result beat leaves per cycle while
// out_ch is ready. One input beat per cycle is taken while the four-entry queue
// holds at most one result; a larger group holds off input until that is so again.
// Synchronous active-low reset empties the window and the queue and clears
// header mode. A stall on the result side backs up only through the queue fill.
module quoted_printable_decoder_top
  import qpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  qpd_in_if.sink     in_ch,
  qpd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic        hdr_mode_r;
  logic        accept;
  logic        space_ok;
  result_grp_t grp;

  // Header mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mode_r <= 1'b0;
    end else if (cfg_we) begin
      hdr_mode_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && in_ch.ready;

  qpd_window_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .hdr_mode  (hdr_mode_r),
    .in_byte   (in_ch.in_byte),
    .last_byte (in_ch.last_byte),
    .grp       (grp)
  );

  qpd_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .grp      (grp),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

// ----- rtl/qpd_window_decode.sv -----
// Lookahead window registers and the single-pass decode of one input beat.
module qpd_window_decode
  import qpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        hdr_mode,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output result_grp_t grp
);

  // The first held byte is always '=', so only the second one is stored.
  logic [1:0] win_cnt_r, win_cnt_nxt;
  logic [7:0] win_b1_r, win_b1_nxt;

  logic [7:0]           rb [MAX_RESULTS];
  logic [GRP_CNT_W-1:0] nr;
  logic                 no_byte;

  // Work out the result bytes and the next window contents.
  always_comb begin
    nr          = '0;
    no_byte     = 1'b0;
    win_cnt_nxt = 2'd0;
    win_b1_nxt  = win_b1_r;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      rb[j] = 8'h00;
    end
    unique case (win_cnt_r)
      2'd0: begin
        if ((in_byte == CH_EQUALS) && !last_byte) begin
          win_cnt_nxt = 2'd1;
        end else begin
          rb[0] = map_plain(in_byte, hdr_mode);
          nr    = GRP_CNT_W'(1);
        end
      end
      2'd1: begin
        if (!last_byte) begin
          win_cnt_nxt = 2'd2;
          win_b1_nxt  = in_byte;
        end else begin
          rb[0] = CH_EQUALS;
          rb[1] = map_plain(in_byte, hdr_mode);
          nr    = GRP_CNT_W'(2);
        end
      end
      2'd2: begin
        if (is_hex(win_b1_r) && is_hex(in_byte)) begin
          rb[0] = {hex_nibble(win_b1_r), hex_nibble(in_byte)};
          nr    = GRP_CNT_W'(1);
        end else if ((win_b1_r == CH_CR) && (in_byte == CH_LF)) begin
          // Soft line break: no decoded byte comes out.
          nr = '0;
        end else if (last_byte) begin
          rb[0] = CH_EQUALS;
          rb[1] = map_plain(win_b1_r, hdr_mode);
          rb[2] = map_plain(in_byte, hdr_mode);
          nr    = GRP_CNT_W'(3);
        end else if (win_b1_r == CH_EQUALS) begin
          // The second '=' starts a new escape with the incoming byte.
          rb[0]       = CH_EQUALS;
          nr          = GRP_CNT_W'(1);
          win_cnt_nxt = 2'd2;
          win_b1_nxt  = in_byte;
        end else begin
          rb[0] = CH_EQUALS;
          rb[1] = map_plain(win_b1_r, hdr_mode);
          if (in_byte == CH_EQUALS) begin
            nr          = GRP_CNT_W'(2);
            win_cnt_nxt = 2'd1;
          end else begin
            rb[2] = map_plain(in_byte, hdr_mode);
            nr    = GRP_CNT_W'(3);
          end
        end
      end
      default: begin
        nr = '0;
      end
    endcase
    // A message always ends with a marked result, empty if need be.
    if (last_byte && (nr == '0)) begin
      nr      = GRP_CNT_W'(1);
      no_byte = 1'b1;
    end
  end

  // Pack the results with their end markers.
  always_comb begin
    grp.count = nr;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      grp.item[j].out_byte    = no_byte ? 8'h00 : rb[j];
      grp.item[j].has_byte    = !no_byte;
      grp.item[j].run_end     = (GRP_CNT_W'(j + 1) == nr);
      grp.item[j].message_end = (GRP_CNT_W'(j + 1) == nr) && last_byte;
    end
  end

  // Window state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= 2'd0;
      win_b1_r  <= 8'h00;
    end else if (accept) begin
      win_cnt_r <= win_cnt_nxt;
      win_b1_r  <= win_b1_nxt;
    end
  end

endmodule

// ----- rtl/qpd_result_queue.sv -----
// Small shifting result queue: takes a group of results, emits one beat a cycle while out_ch is ready.
module qpd_result_queue
  import qpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  result_grp_t   grp,
  output logic          space_ok,
  qpd_out_if.source     out_ch
);

  result_t              q_r   [QUEUE_DEPTH];
  result_t              q_nxt [QUEUE_DEPTH];
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [Q_CNT_W-1:0]   base;
  logic [Q_CNT_W-1:0]   slot  [MAX_RESULTS];
  logic [Q_CNT_W-1:0]   add;
  logic                 pop;

  // Head of the queue drives the result channel.
  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_byte    = q_r[0].out_byte;
  assign out_ch.has_byte    = q_r[0].has_byte;
  assign out_ch.run_end     = q_r[0].run_end;
  assign out_ch.message_end = q_r[0].message_end;

  assign pop = out_ch.valid && out_ch.ready;

  // A full group always fits when the queue is this empty.
  assign space_ok = (cnt_r <= Q_CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

  // Shift out the head beat, then append the new group behind what is left.
  always_comb begin
    q_nxt = q_r;
    base  = cnt_r;
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      base = cnt_r - Q_CNT_W'(1);
    end
    add = push ? Q_CNT_W'(grp.count) : '0;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      slot[j] = base + Q_CNT_W'(j);
      if (push && (GRP_CNT_W'(j) < grp.count)) begin
        q_nxt[slot[j][Q_IDX_W-1:0]] = grp.item[j];
      end
    end
    cnt_nxt = base + add;
  end

  // Entry payload needs no reset; the fill count does.
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
